>>> rtl/lld_pkg.sv
// Shared constants for the 3D line-to-line closest distance pipeline.
package lld_pkg;

	localparam logic [31:0] EPS_RESET = 32'd4295;

	// Latency of one pipelined multiplier.
	localparam int MUL_LAT = 3;

	// Number of result bits found by the square-root search.
	localparam int ROOT_BITS = 40;

	// Widths of the operands handed to the square-root search.
	localparam int ROOT_NUM_W = 210;
	localparam int ROOT_K_W   = 136;

	// Difference stage, three multiplier groups, three sum stages, root search.
	localparam int PIPE_LAT = 4 + 3 * MUL_LAT + ROOT_BITS;

endpackage

>>> rtl/lld_delay.sv
// Enabled delay line used to keep side data aligned with the pipeline.
module lld_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				pipe_s[i] <= pipe_s[i-1];
			end
		end
	end

	assign q = pipe_s[N-1];

endmodule

>>> rtl/lld_mul.sv
// Pipelined signed multiplier built from 32 by 32 bit partial products.
module lld_mul #(
	parameter int WA = 33,
	parameter int WB = 33
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int NA = (WA + 31) / 32;
	localparam int NB = (WB + 31) / 32;
	localparam int WP = WA + WB;

	logic [WA-1:0] amag;
	logic [WB-1:0] bmag;
	logic [NA*32-1:0] am_s1;
	logic [NB*32-1:0] bm_s1;
	logic neg_s1, neg_s2;
	logic [63:0] pp_s2 [NA][NB];
	logic [WP-1:0] sum;

	// Work on magnitudes; the sign is put back after the sum.
	assign amag = a[WA-1] ? WA'(-a) : WA'(a);
	assign bmag = b[WB-1] ? WB'(-b) : WB'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= (NA*32)'(amag);
			bm_s1  <= (NB*32)'(bmag);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			neg_s2 <= neg_s1;
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= 64'(am_s1[i*32 +: 32]) * 64'(bm_s1[j*32 +: 32]);
				end
			end
			p <= neg_s2 ? WP'(-sum) : WP'(sum);
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (WP'(pp_s2[i][j]) << (32 * (i + j)));
			end
		end
	end

endmodule

>>> rtl/lld_root.sv
// Pipelined search for the largest m with m*m*k <= num, one result bit a stage.
module lld_root #(
	parameter int NW = 210,
	parameter int KW = 136,
	parameter int MB = 40
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [KW-1:0] k,
	output logic [MB-1:0] root
);

	localparam int W1 = KW + MB;
	localparam int W2 = KW + 2 * MB;

	logic [MB-1:0] m_s   [MB];
	logic [W1-1:0] mk_s  [MB];
	logic [W2-1:0] m2k_s [MB];
	logic [NW-1:0] num_s [MB];
	logic [KW-1:0] k_s   [MB];

	for (genvar g = 0; g < MB; g++) begin : g_stage
		localparam int B = MB - 1 - g;
		logic [MB-1:0] m_in;
		logic [W1-1:0] mk_in;
		logic [W2-1:0] m2k_in;
		logic [NW-1:0] num_in;
		logic [KW-1:0] k_in;
		logic [W2-1:0] trial;
		logic          take;

		if (g == 0) begin : g_first
			assign m_in   = '0;
			assign mk_in  = '0;
			assign m2k_in = '0;
			assign num_in = num;
			assign k_in   = k;
		end else begin : g_next
			assign m_in   = m_s[g-1];
			assign mk_in  = mk_s[g-1];
			assign m2k_in = m2k_s[g-1];
			assign num_in = num_s[g-1];
			assign k_in   = k_s[g-1];
		end

		// (m + 2^B)^2 k = m^2 k + 2^(B+1) m k + 2^(2B) k
		assign trial = m2k_in + (W2'(mk_in) << (B + 1)) + (W2'(k_in) << (2 * B));
		assign take  = trial <= W2'(num_in);

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g]   <= take ? (m_in | (MB'(1) << B)) : m_in;
				m2k_s[g] <= take ? trial : m2k_in;
				mk_s[g]  <= take ? (mk_in + (W1'(k_in) << B)) : mk_in;
				num_s[g] <= num_in;
				k_s[g]   <= k_in;
			end
		end
	end

	assign root = m_s[MB-1];

endmodule

>>> rtl/line_line_closest_distance_3d_top.sv
// Top level of the pipelined shortest distance between two 3D lines.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -------------------------------------------
//  in        in_valid / in_stall     line_a_*, line_b_* (12 x signed Q16.16)
//  out       out_valid / out_stall   distance (unsigned Q24.16, 40 bits)
//  cfg       cfg_wr_en               cfg_wr_data (eps_threshold, 32 bits)
//
// One item enters every cycle while no result is stalled; the depth of the
// pipeline is set by three chained multiplier groups of three stages each and
// the square-root search, which resolves one result bit per stage.
// Reset clears the valid bits of the pipeline and loads the threshold with
// its default; data registers are not reset.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module line_line_closest_distance_3d_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] line_a_start_x,
	input  logic signed [31:0] line_a_start_y,
	input  logic signed [31:0] line_a_start_z,
	input  logic signed [31:0] line_a_end_x,
	input  logic signed [31:0] line_a_end_y,
	input  logic signed [31:0] line_a_end_z,
	input  logic signed [31:0] line_b_start_x,
	input  logic signed [31:0] line_b_start_y,
	input  logic signed [31:0] line_b_start_z,
	input  logic signed [31:0] line_b_end_x,
	input  logic signed [31:0] line_b_end_y,
	input  logic signed [31:0] line_b_end_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [39:0]        distance,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);

	localparam int LAT = lld_pkg::PIPE_LAT;

	logic [31:0]    eps_q;
	logic [LAT-1:0] vld_q;
	logic           adv;

	// The user must write the threshold only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= lld_pkg::EPS_RESET;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// The pipeline moves unless a finished result is held by the consumer.
	assign adv       = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: the three difference vectors C0 = As - Bs, Cp = Ae - As, Cq = Bs - Be.
	logic signed [31:0] as_v [3], ae_v [3], bs_v [3], be_v [3];
	logic signed [32:0] c0_s1 [3], cp_s1 [3], cq_s1 [3];

	assign as_v[0] = line_a_start_x;
	assign as_v[1] = line_a_start_y;
	assign as_v[2] = line_a_start_z;
	assign ae_v[0] = line_a_end_x;
	assign ae_v[1] = line_a_end_y;
	assign ae_v[2] = line_a_end_z;
	assign bs_v[0] = line_b_start_x;
	assign bs_v[1] = line_b_start_y;
	assign bs_v[2] = line_b_start_z;
	assign be_v[0] = line_b_end_x;
	assign be_v[1] = line_b_end_y;
	assign be_v[2] = line_b_end_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c0_s1[i] <= 33'(as_v[i]) - 33'(bs_v[i]);
				cp_s1[i] <= 33'(ae_v[i]) - 33'(as_v[i]);
				cq_s1[i] <= 33'(bs_v[i]) - 33'(be_v[i]);
			end
		end
	end

	// First multiplier group: cross product terms, C0.Cp and Cp.Cp terms.
	logic signed [65:0] crs_a [3], crs_b [3], dcp_p [3], cpp_p [3];
	logic signed [32:0] c0_d5 [3], cp_d5 [3];

	for (genvar i = 0; i < 3; i++) begin : g_grp1
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		lld_mul #(.WA(33), .WB(33)) u_crs_a (
			.clk(clk), .en(adv), .a(cp_s1[J]), .b(cq_s1[K]), .p(crs_a[i])
		);
		lld_mul #(.WA(33), .WB(33)) u_crs_b (
			.clk(clk), .en(adv), .a(cp_s1[K]), .b(cq_s1[J]), .p(crs_b[i])
		);
		lld_mul #(.WA(33), .WB(33)) u_dcp (
			.clk(clk), .en(adv), .a(c0_s1[i]), .b(cp_s1[i]), .p(dcp_p[i])
		);
		lld_mul #(.WA(33), .WB(33)) u_cpp (
			.clk(clk), .en(adv), .a(cp_s1[i]), .b(cp_s1[i]), .p(cpp_p[i])
		);
		lld_delay #(.W(33), .N(lld_pkg::MUL_LAT + 1)) u_c0_dly (
			.clk(clk), .en(adv), .d(c0_s1[i]), .q(c0_d5[i])
		);
		lld_delay #(.W(33), .N(lld_pkg::MUL_LAT + 1)) u_cp_dly (
			.clk(clk), .en(adv), .d(cp_s1[i]), .q(cp_d5[i])
		);
	end

	// Stage 5: normal vector Cp x Cq, guarded A11 + eps and B1 = -C0.Cp.
	logic [67:0]        a11_c;
	logic [68:0]        e_c;
	logic signed [68:0] b1_c;
	logic signed [66:0] nv_s5 [3];
	logic signed [69:0] e_s5;
	logic signed [68:0] b1_s5;

	always_comb begin
		a11_c = 68'(cpp_p[0]) + 68'(cpp_p[1]) + 68'(cpp_p[2]);
		e_c   = 69'(a11_c) + 69'(eps_q);
		// A degenerate line A with a zero threshold gives p = 0.
		if (e_c == '0) begin
			e_c = 69'd1;
		end
		b1_c = -(69'(dcp_p[0]) + 69'(dcp_p[1]) + 69'(dcp_p[2]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nv_s5[i] <= 67'(crs_a[i]) - 67'(crs_b[i]);
			end
			e_s5  <= {1'b0, e_c};
			b1_s5 <= b1_c;
		end
	end

	// Second multiplier group: |n|^2 terms, C0.n terms, the parallel-case
	// residual terms E*C0 and B1*Cp, and E^2.
	logic signed [133:0] nv2_p [3];
	logic signed [99:0]  cnv_p [3];
	logic signed [102:0] ec0_p [3];
	logic signed [101:0] b1cp_p [3];
	logic signed [139:0] ee_p;

	for (genvar i = 0; i < 3; i++) begin : g_grp2
		lld_mul #(.WA(67), .WB(67)) u_nv2 (
			.clk(clk), .en(adv), .a(nv_s5[i]), .b(nv_s5[i]), .p(nv2_p[i])
		);
		lld_mul #(.WA(33), .WB(67)) u_cnv (
			.clk(clk), .en(adv), .a(c0_d5[i]), .b(nv_s5[i]), .p(cnv_p[i])
		);
		lld_mul #(.WA(70), .WB(33)) u_ec0 (
			.clk(clk), .en(adv), .a(e_s5), .b(c0_d5[i]), .p(ec0_p[i])
		);
		lld_mul #(.WA(69), .WB(33)) u_b1cp (
			.clk(clk), .en(adv), .a(b1_s5), .b(cp_d5[i]), .p(b1cp_p[i])
		);
	end

	lld_mul #(.WA(70), .WB(70)) u_ee (
		.clk(clk), .en(adv), .a(e_s5), .b(e_s5), .p(ee_p)
	);

	// Stage 9: determinant, triple product and parallel-case residual vector.
	logic [135:0]        det_s9;
	logic signed [101:0] s_s9;
	logic signed [103:0] v_s9 [3];
	logic [135:0]        e2_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s9 <= 136'(nv2_p[0]) + 136'(nv2_p[1]) + 136'(nv2_p[2]);
			s_s9   <= 102'(cnv_p[0]) + 102'(cnv_p[1]) + 102'(cnv_p[2]);
			for (int i = 0; i < 3; i++) begin
				v_s9[i] <= 104'(ec0_p[i]) + 104'(b1cp_p[i]);
			end
			e2_s9 <= ee_p[135:0];
		end
	end

	// Stage 10: the nearly-parallel decision. A zero determinant always counts
	// as parallel, also with a zero threshold.
	logic par_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			par_s10 <= (det_s9 == '0) || (det_s9 < 136'({eps_q, 32'd0}));
		end
	end

	// Third multiplier group: squares of the triple product and residual terms.
	logic signed [203:0] ss_p;
	logic signed [207:0] vv_p [3];
	logic [135:0]        det_d12, e2_d12;
	logic                par_d12;

	lld_mul #(.WA(102), .WB(102)) u_ss (
		.clk(clk), .en(adv), .a(s_s9), .b(s_s9), .p(ss_p)
	);

	for (genvar i = 0; i < 3; i++) begin : g_grp3
		lld_mul #(.WA(104), .WB(104)) u_vv (
			.clk(clk), .en(adv), .a(v_s9[i]), .b(v_s9[i]), .p(vv_p[i])
		);
	end

	lld_delay #(.W(136), .N(lld_pkg::MUL_LAT)) u_det_dly (
		.clk(clk), .en(adv), .d(det_s9), .q(det_d12)
	);
	lld_delay #(.W(136), .N(lld_pkg::MUL_LAT)) u_e2_dly (
		.clk(clk), .en(adv), .d(e2_s9), .q(e2_d12)
	);
	lld_delay #(.W(1), .N(lld_pkg::MUL_LAT - 1)) u_par_dly (
		.clk(clk), .en(adv), .d(par_s10), .q(par_d12)
	);

	// Stage 13: pick numerator and scale of the root search for the branch.
	// Skew lines:     distance^2 = (C0.n)^2 / det.
	// Nearly parallel: distance^2 = |E*C0 + B1*Cp|^2 / E^2.
	logic [lld_pkg::ROOT_NUM_W-1:0] num_s13;
	logic [lld_pkg::ROOT_K_W-1:0]   k_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (par_d12) begin
				num_s13 <= lld_pkg::ROOT_NUM_W'(vv_p[0]) + lld_pkg::ROOT_NUM_W'(vv_p[1])
					+ lld_pkg::ROOT_NUM_W'(vv_p[2]);
				k_s13   <= lld_pkg::ROOT_K_W'(e2_d12);
			end else begin
				num_s13 <= lld_pkg::ROOT_NUM_W'(ss_p);
				k_s13   <= lld_pkg::ROOT_K_W'(det_d12);
			end
		end
	end

	// The root search settles one distance bit per stage; its range caps the
	// result at the top of the Q24.16 range, which is the saturation.
	lld_root #(
		.NW(lld_pkg::ROOT_NUM_W),
		.KW(lld_pkg::ROOT_K_W),
		.MB(lld_pkg::ROOT_BITS)
	) u_root (
		.clk(clk),
		.en(adv),
		.num(num_s13),
		.k(k_s13),
		.root(distance)
	);

endmodule
